### hdl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: power sequencing controller definitions
// Beat layouts, mode encoding, register indexes and field codes.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned MvW      = 13;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ReasonW  = 2;
  localparam int unsigned ChargeW  = 2;
  localparam int unsigned RunW     = 3;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  localparam logic [MvW-1:0]     TurnOnMinRst  = 13'd3400;
  localparam logic [MvW-1:0]     CriticalMvRst = 13'd3200;
  localparam logic [CountW-1:0]  TimeoutRst    = 16'd5000;
  localparam logic [ReasonW-1:0] StartRsnRst   = 2'd0;

  localparam logic [ChargeW-1:0] ChgOff      = 2'd0;
  localparam logic [ChargeW-1:0] ChgCharging = 2'd1;
  localparam logic [ChargeW-1:0] ChgDone     = 2'd2;

  localparam logic [ReasonW-1:0] ReasonNone    = 2'd0;
  localparam logic [ReasonW-1:0] ReasonAlarm   = 2'd1;
  localparam logic [ReasonW-1:0] ReasonCharger = 2'd2;
  localparam logic [ReasonW-1:0] ReasonButton  = 2'd3;

  localparam logic [RunW-1:0] RunWake   = 3'd0;
  localparam logic [RunW-1:0] RunCharge = 3'd1;
  localparam logic [RunW-1:0] RunWait   = 3'd2;
  localparam logic [RunW-1:0] RunPower  = 3'd3;
  localparam logic [RunW-1:0] RunPoff   = 3'd4;
  localparam logic [RunW-1:0] RunSleep  = 3'd5;

  localparam logic KindStart = 1'b0;

  typedef enum logic [5:0] {
    ModeWake   = 6'b000001,
    ModeCharge = 6'b000010,
    ModeWait   = 6'b000100,
    ModePower  = 6'b001000,
    ModePoff   = 6'b010000,
    ModeSleep  = 6'b100000
  } mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgTurnOnMin   = 2'd0,
    CfgCriticalMv  = 2'd1,
    CfgTimeout     = 2'd2,
    CfgStartReason = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               pad;
    logic               shutdown_request;
    logic               wake_on_charge_done;
    logic               wake_on_charge_start;
    logic               wake_on_alarm;
    logic               rtc_alarm_seen;
    logic               button_long_press;
    logic               button_short_expired;
    logic               button_down;
    logic [ChargeW-1:0] charge_state;
    logic [MvW-1:0]     battery_mv;
  } in_item_t;

  typedef struct packed {
    logic               pad;
    logic               clear_press_status;
    logic               consume_long_press;
    logic               clear_alarm;
    logic               clear_shutdown;
    logic               clear_wake_control;
    logic               critical_flag;
    logic [ReasonW-1:0] power_on_reason;
    logic               bus_enabled;
    logic               backlight_on;
    logic               vref_power_on;
    logic               main_power_on;
    logic [RunW-1:0]    run_mode;
  } out_item_t;

  function automatic logic [RunW-1:0] run_code(mode_e m);
    logic [RunW-1:0] code;
    case (m)
      ModeWake:   code = RunWake;
      ModeCharge: code = RunCharge;
      ModeWait:   code = RunWait;
      ModePower:  code = RunPower;
      ModePoff:   code = RunPoff;
      ModeSleep:  code = RunSleep;
      default:    code = RunWake;
    endcase
    return code;
  endfunction

endpackage

### hdl/power_sequencing_controller.sv
// An accepted beat is held in the input register and its result beat in the result register.
// Throughput: one beat per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset: mode wake, countdown 5000, bus enable on, other enables, critical flag
// and reason cleared; config registers return to their documented defaults.
// ----------------------------------------------------------------------------
// power_sequencing_controller
// Six-state power sequencer: start and tick beats choose the next mode and
// drive supply enables, power-on reason, critical flag and clear pulses.
// ----------------------------------------------------------------------------
module power_sequencing_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [psc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // battery_mv[12:0], charge_state[14:13], button_down, button_short_expired,
  // button_long_press, rtc_alarm_seen, wake_on_alarm, wake_on_charge_start,
  // wake_on_charge_done, shutdown_request[22], zero pad
  input  logic [psc_pkg::InDataW-1:0]   s_axis_tdata,
  // kind
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // run_mode[2:0], main_power_on, vref_power_on, backlight_on, bus_enabled,
  // power_on_reason[8:7], critical_flag, clear_wake_control, clear_shutdown,
  // clear_alarm, consume_long_press, clear_press_status[14], zero pad
  output logic [psc_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [psc_pkg::MvW-1:0]     turn_on_q, crit_mv_q;
  logic [psc_pkg::CountW-1:0]  timeout_q;
  logic [psc_pkg::ReasonW-1:0] start_rsn_q;

  logic              in_valid_q;
  logic              kind_q;
  psc_pkg::in_item_t in_q;

  logic               m_valid_q;
  psc_pkg::out_item_t out_q, out_d;

  psc_pkg::mode_e              mode_q, mode_d;
  logic [psc_pkg::CountW-1:0]  count_q, count_d;
  logic                        crit_q, crit_d;
  logic                        main_q, main_d;
  logic                        vref_q, vref_d;
  logic                        bl_q, bl_d;
  logic                        bus_q, bus_d;
  logic [psc_pkg::ReasonW-1:0] reason_q, reason_d;

  logic                        advance, proc;
  logic                        batt_ok, do_enter, pwr_up;
  psc_pkg::mode_e              tgt;
  logic [psc_pkg::ReasonW-1:0] up_reason;
  logic                        p_wake, p_shut, p_alarm, p_long, p_press;

  assign advance       = !m_valid_q || m_axis_tready;
  assign proc          = advance && in_valid_q;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_on_q   <= psc_pkg::TurnOnMinRst;
      crit_mv_q   <= psc_pkg::CriticalMvRst;
      timeout_q   <= psc_pkg::TimeoutRst;
      start_rsn_q <= psc_pkg::StartRsnRst;
    end else if (cfg_we_i) begin
      case (psc_pkg::cfg_idx_e'(cfg_addr_i))
        psc_pkg::CfgTurnOnMin:   turn_on_q   <= cfg_wdata_i[psc_pkg::MvW-1:0];
        psc_pkg::CfgCriticalMv:  crit_mv_q   <= cfg_wdata_i[psc_pkg::MvW-1:0];
        psc_pkg::CfgTimeout:     timeout_q   <= cfg_wdata_i[psc_pkg::CountW-1:0];
        psc_pkg::CfgStartReason: start_rsn_q <= cfg_wdata_i[psc_pkg::ReasonW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      in_q   <= psc_pkg::in_item_t'(s_axis_tdata);
    end
  end

  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    crit_d    = crit_q;
    main_d    = main_q;
    vref_d    = vref_q;
    bl_d      = bl_q;
    bus_d     = bus_q;
    reason_d  = reason_q;
    do_enter  = 1'b0;
    pwr_up    = 1'b0;
    tgt       = psc_pkg::ModeWake;
    up_reason = psc_pkg::ReasonNone;
    p_wake    = 1'b0;
    p_shut    = 1'b0;
    p_alarm   = 1'b0;
    p_long    = 1'b0;
    p_press   = 1'b0;
    batt_ok   = in_q.battery_mv >= turn_on_q;

    if (kind_q == psc_pkg::KindStart) begin
      do_enter = 1'b1;
      tgt = (!batt_ok && in_q.charge_state != psc_pkg::ChgCharging) ?
            psc_pkg::ModeSleep : psc_pkg::ModeWake;
    end else begin
      case (mode_q)
        psc_pkg::ModeWake: begin
          if (start_rsn_q[0] && in_q.wake_on_alarm && batt_ok) begin
            p_alarm   = 1'b1;
            pwr_up    = 1'b1;
            up_reason = psc_pkg::ReasonAlarm;
          end else if (start_rsn_q[1]) begin
            if ((in_q.wake_on_charge_start && in_q.charge_state == psc_pkg::ChgCharging
                 && batt_ok) ||
                (in_q.wake_on_charge_done && in_q.charge_state == psc_pkg::ChgDone
                 && batt_ok)) begin
              pwr_up    = 1'b1;
              up_reason = psc_pkg::ReasonCharger;
            end else begin
              do_enter = 1'b1;
              tgt = (in_q.charge_state != psc_pkg::ChgOff) ?
                    psc_pkg::ModeCharge : psc_pkg::ModeSleep;
            end
          end else if (in_q.button_short_expired && batt_ok) begin
            do_enter = 1'b1;
            tgt      = psc_pkg::ModeWait;
          end else if (!in_q.button_down) begin
            do_enter = 1'b1;
            tgt      = psc_pkg::ModeSleep;
          end
        end
        psc_pkg::ModeCharge: begin
          if (batt_ok) begin
            if (in_q.rtc_alarm_seen && in_q.wake_on_alarm) begin
              p_alarm   = 1'b1;
              pwr_up    = 1'b1;
              up_reason = psc_pkg::ReasonAlarm;
            end else if (in_q.button_short_expired) begin
              do_enter = 1'b1;
              tgt      = psc_pkg::ModeWait;
            end else if (in_q.charge_state == psc_pkg::ChgDone &&
                         in_q.wake_on_charge_done) begin
              pwr_up    = 1'b1;
              up_reason = psc_pkg::ReasonCharger;
            end else if (in_q.charge_state == psc_pkg::ChgOff) begin
              do_enter = 1'b1;
              tgt      = psc_pkg::ModeSleep;
            end
          end else if (in_q.charge_state == psc_pkg::ChgOff) begin
            do_enter = 1'b1;
            tgt      = psc_pkg::ModeSleep;
          end
        end
        psc_pkg::ModeWait: begin
          if (!in_q.button_down) begin
            pwr_up    = 1'b1;
            up_reason = psc_pkg::ReasonButton;
            p_long    = 1'b1;
            p_press   = 1'b1;
          end
        end
        psc_pkg::ModePower: begin
          if (in_q.battery_mv < crit_mv_q) begin
            if (count_q == timeout_q) begin
              crit_d = 1'b1;
            end
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
          end else begin
            count_d = timeout_q;
            crit_d  = 1'b0;
          end
          p_long = 1'b1;
          if (in_q.button_long_press) begin
            do_enter = 1'b1;
            tgt      = psc_pkg::ModePoff;
          end else if (count_d == '0 || in_q.shutdown_request) begin
            do_enter = 1'b1;
            tgt = (in_q.charge_state == psc_pkg::ChgOff) ?
                  psc_pkg::ModeSleep : psc_pkg::ModeCharge;
          end
        end
        psc_pkg::ModePoff: begin
          if (!in_q.button_down) begin
            do_enter = 1'b1;
            tgt = (in_q.charge_state == psc_pkg::ChgOff) ?
                  psc_pkg::ModeSleep : psc_pkg::ModeCharge;
            p_long = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (pwr_up) begin
      reason_d = up_reason;
      p_wake   = 1'b1;
      do_enter = 1'b1;
      tgt      = psc_pkg::ModePower;
    end

    if (do_enter) begin
      mode_d = tgt;
      case (tgt)
        psc_pkg::ModeWake: begin
          vref_d = 1'b1;
          main_d = 1'b0;
          bl_d   = 1'b0;
        end
        psc_pkg::ModeCharge: begin
          main_d = 1'b0;
          bl_d   = 1'b0;
          bus_d  = 1'b0;
          p_shut = 1'b1;
        end
        psc_pkg::ModeWait: begin
          main_d = 1'b1;
          bl_d   = 1'b1;
        end
        psc_pkg::ModePower: begin
          main_d  = 1'b1;
          bl_d    = 1'b1;
          bus_d   = 1'b1;
          count_d = timeout_q;
        end
        psc_pkg::ModePoff: begin
          main_d = 1'b0;
          bl_d   = 1'b0;
        end
        default: begin
          main_d  = 1'b0;
          vref_d  = 1'b0;
          bl_d    = 1'b0;
          bus_d   = 1'b0;
          p_shut  = 1'b1;
          p_alarm = 1'b1;
        end
      endcase
    end

    out_d                    = '0;
    out_d.run_mode           = psc_pkg::run_code(mode_d);
    out_d.main_power_on      = main_d;
    out_d.vref_power_on      = vref_d;
    out_d.backlight_on       = bl_d;
    out_d.bus_enabled        = bus_d;
    out_d.power_on_reason    = reason_d;
    out_d.critical_flag      = crit_d;
    out_d.clear_wake_control = p_wake;
    out_d.clear_shutdown     = p_shut;
    out_d.clear_alarm        = p_alarm;
    out_d.consume_long_press = p_long;
    out_d.clear_press_status = p_press;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= psc_pkg::ModeWake;
      count_q  <= psc_pkg::TimeoutRst;
      crit_q   <= 1'b0;
      main_q   <= 1'b0;
      vref_q   <= 1'b0;
      bl_q     <= 1'b0;
      bus_q    <= 1'b1;
      reason_q <= psc_pkg::ReasonNone;
    end else if (proc) begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      crit_q   <= crit_d;
      main_q   <= main_d;
      vref_q   <= vref_d;
      bl_q     <= bl_d;
      bus_q    <= bus_d;
      reason_q <= reason_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= out_d;
    end
  end

  a_result_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(in_valid_q))
    else $error("result beat without a buffered input beat");

  a_press_pulses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q.clear_press_status) |->
      (out_q.consume_long_press && out_q.clear_wake_control &&
       out_q.power_on_reason == psc_pkg::ReasonButton))
    else $error("press clear without button power-up");

  a_sleep_all_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q.run_mode == psc_pkg::RunSleep) |->
      (!out_q.main_power_on && !out_q.vref_power_on &&
       !out_q.backlight_on && !out_q.bus_enabled))
    else $error("supply enabled in sleep");

  a_power_all_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q.run_mode == psc_pkg::RunPower) |->
      (out_q.main_power_on && out_q.backlight_on && out_q.bus_enabled))
    else $error("supply disabled in power mode");

endmodule
